>>> rtl/sample_clip_queue_player_macros.svh
// Assertion macros used by the checker file.
`ifndef SAMPLE_CLIP_QUEUE_PLAYER_MACROS_SVH
`define SAMPLE_CLIP_QUEUE_PLAYER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SCQP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SCQP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/scqp_pkg.sv
`default_nettype none

package scqp_pkg;

   localparam int QUEUE_DEPTH     = 32;
   localparam int STORE_ADDR_BITS = 14;
   localparam int STORE_DEPTH     = 1 << STORE_ADDR_BITS;
   localparam int PTR_W           = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W         = $clog2(QUEUE_DEPTH + 1);
   localparam int OP_W            = 2;
   localparam int START_W         = 14;
   localparam int LEN_W           = 15;
   localparam int BYTE_W          = 8;
   localparam int QUEUED_W        = 6;

   localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
   localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD    = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [START_W-1:0] clip_start;
      logic [LEN_W-1:0]   clip_length;
      logic [BYTE_W-1:0]  load_byte;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   level;
      logic                level_new;
      logic                clip_done;
      logic                idle;
      logic [QUEUED_W-1:0] queued;
      logic                rejected;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic fetch;
      logic commit;
      logic play;
      logic pop;
      logic push;
      logic reject;
      logic store;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            ring_empty;
      logic            ring_full;
      logic            sample_left;
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/scqp_ctrl.sv
`default_nettype none

module scqp_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   input  scqp_pkg::sts_type sts,
   output scqp_pkg::cmd_type cmd
);
   import scqp_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_DESC  = 2'd1;
   localparam logic [1:0] S_FETCH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DESC;
            end
         end
         S_DESC: begin
            cmd.fetch = 1'b1;
            state_in  = S_FETCH;
         end
         S_FETCH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               case (sts.op)
                  OP_TICK: begin
                     if (!sts.ring_empty) begin
                        cmd.play = sts.sample_left;
                        cmd.pop  = !sts.sample_left;
                     end
                  end
                  OP_ENQUEUE: begin
                     cmd.reject = sts.ring_full;
                     cmd.push   = !sts.ring_full;
                  end
                  OP_LOAD: begin
                     cmd.store = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/scqp_datapath.sv
`default_nettype none

module scqp_datapath (
   input  wire               clock,
   input  wire               reset,
   input  scqp_pkg::req_type req_data,
   input  scqp_pkg::cmd_type cmd,
   output scqp_pkg::sts_type sts,
   output scqp_pkg::rsp_type rsp_data
);
   import scqp_pkg::*;

   logic [START_W-1:0] start_mem [QUEUE_DEPTH];
   logic [LEN_W-1:0]   len_mem   [QUEUE_DEPTH];
   logic [BYTE_W-1:0]  store_mem [STORE_DEPTH];

   req_type              item_ff;
   logic [START_W-1:0]   desc_start_ff;
   logic [LEN_W-1:0]     desc_len_ff;
   logic [BYTE_W-1:0]    store_data_ff;
   rsp_type              rsp_ff, rsp_in;

   logic [PTR_W-1:0]     head_ff, head_in;
   logic [PTR_W-1:0]     tail_ff, tail_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [LEN_W-1:0]     index_ff, index_in;
   logic [BYTE_W-1:0]    level_ff, level_in;
   logic [STORE_ADDR_BITS-1:0] fetch_addr;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign fetch_addr = STORE_ADDR_BITS'(desc_start_ff) + index_ff[STORE_ADDR_BITS-1:0];

   assign sts.op          = item_ff.op;
   assign sts.ring_empty  = (count_ff == '0);
   assign sts.ring_full   = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign sts.sample_left = (index_ff < desc_len_ff);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      index_in = index_ff;
      level_in = level_ff;
      if (cmd.play) begin
         level_in = store_data_ff;
         index_in = index_ff + LEN_W'(1);
      end
      if (cmd.pop) begin
         head_in  = ptr_next(head_ff);
         count_in = count_ff - COUNT_W'(1);
         index_in = '0;
      end
      if (cmd.push) begin
         tail_in  = ptr_next(tail_ff);
         count_in = count_ff + COUNT_W'(1);
      end
      rsp_in.level     = level_in;
      rsp_in.level_new = cmd.play;
      rsp_in.clip_done = cmd.pop;
      rsp_in.idle      = (count_in == '0);
      rsp_in.queued    = QUEUED_W'(count_in);
      rsp_in.rejected  = cmd.reject;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         index_ff <= '0;
         level_ff <= '0;
      end else if (cmd.commit) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         index_ff <= index_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff       <= req_data;
         desc_start_ff <= start_mem[head_ff];
         desc_len_ff   <= len_mem[head_ff];
      end
      if (cmd.push) begin
         start_mem[tail_ff] <= item_ff.clip_start;
         len_mem[tail_ff]   <= item_ff.clip_length;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         store_data_ff <= store_mem[fetch_addr];
      end
      if (cmd.store) begin
         store_mem[item_ff.clip_start[STORE_ADDR_BITS-1:0]] <= item_ff.load_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/sample_clip_queue_player.sv
// Items are handled one at a time: descriptor read, then sample read,
// then commit; a new item is taken only after the commit, and a stalled
// result holds the commit until it is taken.
// Reset: synchronous, active high; empties the clip queue and zeroes the
// index and level. Descriptor and sample memories are not cleared.
`default_nettype none

module sample_clip_queue_player (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  scqp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output scqp_pkg::rsp_type rsp_data
);
   import scqp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   scqp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   scqp_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/scqp_checker.sv
`default_nettype none
`include "sample_clip_queue_player_macros.svh"

module scqp_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input scqp_pkg::rsp_type rsp_data,
   input wire               rsp_valid,
   input wire               rsp_ready
);
   import scqp_pkg::*;

   `SCQP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")
   `SCQP_ASSERT_NOW(a_idle_count, clock, reset, rsp_valid, rsp_data.idle == (rsp_data.queued == '0), "idle disagrees with queued")
   `SCQP_ASSERT_NOW(a_one_event, clock, reset, rsp_valid, !(rsp_data.level_new && rsp_data.clip_done), "sample and pop in one transfer")
   `SCQP_ASSERT_NOW(a_reject_full, clock, reset, rsp_valid && rsp_data.rejected, rsp_data.queued == QUEUED_W'(QUEUE_DEPTH), "reject while queue not full")
   `SCQP_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "second transfer accepted while busy")

endmodule

bind sample_clip_queue_player scqp_checker u_scqp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);

`default_nettype wire
